/* design/rcsfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsfr_pkg: shared types and constants of the serial RC frame receiver
// Item structs, phase codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package rcsfr_pkg;

    // Build-time defaults
    localparam int CHANNEL_COUNT_DEF = 14;
    localparam int FRAME_BYTES_DEF   = 32;
    localparam int HEADER_OVERHEAD   = 3;

    // Checksum seed
    localparam logic [15:0] SUM_SEED = 16'hFFFF;

    // Frame parser phases
    localparam logic [2:0] PH_LENGTH  = 3'd0;
    localparam logic [2:0] PH_DATA    = 3'd1;
    localparam logic [2:0] PH_SUM_LO  = 3'd2;
    localparam logic [2:0] PH_SUM_HI  = 3'd3;
    localparam logic [2:0] PH_DISCARD = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_GAP_THRESHOLD    = 2'd0;
    localparam logic [1:0] CFG_MAX_FRAME_LENGTH = 2'd1;
    localparam logic [1:0] CFG_SERVO_COMMAND    = 2'd2;

    // Configuration reset values
    localparam logic [7:0] GAP_THRESHOLD_RST    = 8'd48;
    localparam logic [5:0] MAX_FRAME_LENGTH_RST = 6'd32;
    localparam logic [7:0] SERVO_COMMAND_RST    = 8'd64;

    // Result kinds
    localparam logic KIND_CHANNEL = 1'b0;
    localparam logic KIND_ALIVE   = 1'b1;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic [7:0] idle_ticks;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [3:0]  channel_index;
        logic [15:0] channel_value;
        logic        last;
    } t_out_item;

    // Status from the shared subtractor
    typedef struct packed {
        logic [15:0] diff;
        logic        zero;
    } t_alu_res;

endpackage

/* design/rcsfr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsfr_ram: generic single-port RAM
// One address for write and read; read data registered.
// ----------------------------------------------------------------------------
module rcsfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/rcsfr_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsfr_alu: shared 16-bit subtractor
// Serves the checksum update and the checksum compare (difference of zero).
// ----------------------------------------------------------------------------
module rcsfr_alu (
    input  logic [15:0]        i_a,
    input  logic [15:0]        i_b,
    output rcsfr_pkg::t_alu_res o_res
);

    logic [15:0] diff;

    // Wrapping subtract and zero detect
    always_comb begin
        diff         = i_a - i_b;
        o_res.diff   = diff;
        o_res.zero   = (diff == 16'd0);
    end

endmodule

/* design/rc_serial_frame_receiver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_serial_frame_receiver: servo frame receiver for a serial RC link
// Parses length / data / checksum framing and emits channel words or link-alive items.
// ----------------------------------------------------------------------------
// Each received byte is taken in the idle state and then passes once through
// the shared 16-bit subtractor in the step state, which updates or checks the
// frame checksum; the input is stalled until the step is done. A checksum-high
// byte that closes a good servo frame then holds the input while each channel
// passes through the two single-port reads of the frame store (S_RD_LO, S_RD_HI)
// and the output register load (S_PUT), which waits while the output is
// stalled; any other good frame holds it for its link-alive item (S_ALIVE).
// The frame store needs no clearing pass after reset:
// per-byte valid bits make unwritten bytes read as zero.
// ----------------------------------------------------------------------------
module rc_serial_frame_receiver #(
    parameter int CHANNEL_COUNT = rcsfr_pkg::CHANNEL_COUNT_DEF,
    parameter int FRAME_BYTES   = rcsfr_pkg::FRAME_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    // input items
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  rcsfr_pkg::t_in_item  i_in_item,
    // result items
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output rcsfr_pkg::t_out_item o_out_item
);

    localparam int          AW        = $clog2(FRAME_BYTES);
    localparam logic [5:0]  FRAME_LIM = 6'(FRAME_BYTES);
    localparam logic [3:0]  LAST_CH   = 4'(CHANNEL_COUNT - 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_STEP  = 3'd1;
    localparam logic [2:0] S_RD_LO = 3'd2;
    localparam logic [2:0] S_RD_HI = 3'd3;
    localparam logic [2:0] S_PUT   = 3'd4;
    localparam logic [2:0] S_ALIVE = 3'd5;

    // Configuration
    logic [7:0] r_gap;
    logic [5:0] r_max_len;
    logic [7:0] r_servo_cmd;

    // Control and frame state
    logic [2:0]             r_state, n_state;
    logic [2:0]             r_phase;
    logic [4:0]             r_wr_idx;
    logic [4:0]             r_data_cnt;
    logic [15:0]            r_sum;
    logic [7:0]             r_sum_lo;
    logic [7:0]             r_cmd;
    logic [FRAME_BYTES-1:0] r_valid;
    logic [3:0]             r_ch;
    logic                   r_rd_ok;
    logic [7:0]             r_lo;
    logic [7:0]             r_byte;
    logic [7:0]             r_idle;
    logic                   r_out_valid;
    rcsfr_pkg::t_out_item   r_out;

    logic [2:0]           eff_phase;
    logic                 len_ok;
    logic [15:0]          alu_a;
    logic [15:0]          alu_b;
    rcsfr_pkg::t_alu_res  alu_res;
    logic [4:0]           rd_addr;
    logic [AW-1:0]        ram_addr;
    logic                 ram_we;
    logic [7:0]           ram_rdata;
    logic                 rd_ok_next;
    logic [4:0]           wr_next;
    logic [7:0]           rd_byte;
    logic                 out_free;
    logic                 in_acc;
    logic                 last_ch;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign last_ch  = (r_ch == LAST_CH);
    assign wr_next  = r_wr_idx + 5'd1;
    assign rd_byte  = r_rd_ok ? ram_rdata : 8'd0;

    // Phase in force for this byte and length check
    always_comb begin
        eff_phase = (r_idle >= r_gap) ? rcsfr_pkg::PH_LENGTH : r_phase;
        len_ok    = (r_byte <= {2'b00, r_max_len}) && (r_byte <= 8'(FRAME_BYTES))
                    && (r_byte > 8'(rcsfr_pkg::HEADER_OVERHEAD));
    end

    // Operand selection for the shared subtractor
    always_comb begin
        case (eff_phase)
            rcsfr_pkg::PH_LENGTH: begin
                alu_a = rcsfr_pkg::SUM_SEED;
                alu_b = {8'd0, r_byte};
            end
            rcsfr_pkg::PH_DATA: begin
                alu_a = r_sum;
                alu_b = {8'd0, r_byte};
            end
            rcsfr_pkg::PH_SUM_HI: begin
                alu_a = r_sum;
                alu_b = {r_byte, r_sum_lo};
            end
            default: begin
                alu_a = r_sum;
                alu_b = 16'd0;
            end
        endcase
    end

    rcsfr_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    // Frame store addressing: write during the step, channel reads after
    always_comb begin
        rd_addr    = (r_state == S_RD_LO) ? {r_ch, 1'b1} : ({r_ch, 1'b0} + 5'd2);
        ram_we     = (r_state == S_STEP) && (eff_phase == rcsfr_pkg::PH_DATA)
                     && ({1'b0, r_wr_idx} < FRAME_LIM);
        ram_addr   = (r_state == S_STEP) ? r_wr_idx[AW-1:0] : rd_addr[AW-1:0];
        rd_ok_next = ({1'b0, rd_addr} < FRAME_LIM) && r_valid[rd_addr[AW-1:0]];
    end

    rcsfr_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_byte),
        .o_rdata (ram_rdata)
    );

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                n_state = S_IDLE;
                if (eff_phase == rcsfr_pkg::PH_SUM_HI && alu_res.zero) begin
                    n_state = (r_cmd == r_servo_cmd) ? S_RD_LO : S_ALIVE;
                end
            end
            S_RD_LO: n_state = S_RD_HI;
            S_RD_HI: n_state = S_PUT;
            S_PUT: begin
                if (out_free) begin
                    n_state = last_ch ? S_IDLE : S_RD_LO;
                end
            end
            S_ALIVE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap       <= rcsfr_pkg::GAP_THRESHOLD_RST;
            r_max_len   <= rcsfr_pkg::MAX_FRAME_LENGTH_RST;
            r_servo_cmd <= rcsfr_pkg::SERVO_COMMAND_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rcsfr_pkg::CFG_GAP_THRESHOLD:    r_gap       <= i_cfg_data;
                rcsfr_pkg::CFG_MAX_FRAME_LENGTH: r_max_len   <= i_cfg_data[5:0];
                rcsfr_pkg::CFG_SERVO_COMMAND:    r_servo_cmd <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer and frame parser state; the parser updates in the step cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase    <= rcsfr_pkg::PH_DISCARD;
            r_wr_idx   <= 5'd0;
            r_data_cnt <= 5'd0;
            r_sum      <= 16'd0;
            r_sum_lo   <= 8'd0;
            r_cmd      <= 8'd0;
            r_valid    <= '0;
            r_ch       <= 4'd0;
        end else begin
            r_state <= n_state;
            if (r_state == S_STEP) begin
                r_ch <= 4'd0;
                case (eff_phase)
                    rcsfr_pkg::PH_LENGTH: begin
                        if (len_ok) begin
                            r_wr_idx   <= 5'd0;
                            r_data_cnt <= r_byte[4:0] - 5'(rcsfr_pkg::HEADER_OVERHEAD);
                            r_sum      <= alu_res.diff;
                            r_phase    <= rcsfr_pkg::PH_DATA;
                        end else begin
                            r_phase    <= rcsfr_pkg::PH_DISCARD;
                        end
                    end
                    rcsfr_pkg::PH_DATA: begin
                        if (ram_we) begin
                            r_valid[r_wr_idx[AW-1:0]] <= 1'b1;
                        end
                        if (r_wr_idx == 5'd0) begin
                            r_cmd <= r_byte;
                        end
                        r_wr_idx <= wr_next;
                        r_sum    <= alu_res.diff;
                        if (wr_next == r_data_cnt) begin
                            r_phase <= rcsfr_pkg::PH_SUM_LO;
                        end
                    end
                    rcsfr_pkg::PH_SUM_LO: begin
                        r_sum_lo <= r_byte;
                        r_phase  <= rcsfr_pkg::PH_SUM_HI;
                    end
                    rcsfr_pkg::PH_SUM_HI: begin
                        r_phase <= rcsfr_pkg::PH_DISCARD;
                    end
                    default: ;
                endcase
            end else if (r_state == S_PUT && out_free && !last_ch) begin
                r_ch <= r_ch + 4'd1;
            end
        end
    end

    // Input capture and read pipeline (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_byte <= i_in_item.rx_byte;
            r_idle <= i_in_item.idle_ticks;
        end
        r_rd_ok <= rd_ok_next;
        if (r_state == S_RD_HI) begin
            r_lo <= rd_byte;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_PUT || r_state == S_ALIVE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PUT && out_free) begin
            r_out.result_kind   <= rcsfr_pkg::KIND_CHANNEL;
            r_out.channel_index <= r_ch;
            r_out.channel_value <= {rd_byte, r_lo};
            r_out.last          <= last_ch;
        end else if (r_state == S_ALIVE && out_free) begin
            r_out.result_kind   <= rcsfr_pkg::KIND_ALIVE;
            r_out.channel_index <= 4'd0;
            r_out.channel_value <= 16'd0;
            r_out.last          <= 1'b1;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Checks
    a_accept_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_STEP))
        else $error("accepted item not processed in following cycle");

    a_data_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == rcsfr_pkg::PH_DATA) |-> (r_wr_idx < r_data_cnt))
        else $error("write index passed the data count");

    a_alive_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.result_kind == rcsfr_pkg::KIND_ALIVE)
        |-> o_out_item.last)
        else $error("link-alive item without last");

    a_last_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.result_kind == rcsfr_pkg::KIND_CHANNEL
         && o_out_item.last) |-> (o_out_item.channel_index == LAST_CH))
        else $error("last flag on wrong channel");

endmodule

/* bench/rc_serial_frame_receiver_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_serial_frame_receiver_tb: self-checking bench for the RC frame receiver
// Feeds received bytes with their idle gaps. These are directed cases,
// register sweeps, a long output hold-off, random frames and noise. A
// byte-level model of the frame parser predicts every channel word and
// link-alive item, and each result item is checked against it in order.
// ----------------------------------------------------------------------------
module rc_serial_frame_receiver_tb;

    localparam int CYCLE_LIMIT   = 500_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 150;
    localparam int RANDOM_ITEMS  = 170;
    localparam int TAIL_ITEMS    = 60;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [1:0]           i_cfg_index = rcsfr_pkg::CFG_GAP_THRESHOLD;
    logic [7:0]           i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    rcsfr_pkg::t_in_item  i_in_item   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    rcsfr_pkg::t_out_item o_out_item;

    // Parser model: configuration and frame state
    logic [7:0]  cfg_gap;
    logic [5:0]  cfg_max_len;
    logic [7:0]  cfg_servo_cmd;
    logic [2:0]  rx_phase;
    logic [4:0]  wr_idx;
    logic [4:0]  payload_len;
    logic [15:0] frame_sum;
    logic [7:0]  sum_lo;
    logic [7:0]  store_copy [rcsfr_pkg::FRAME_BYTES_DEF];

    rcsfr_pkg::t_out_item pending_results [$];

    int error_count = 0;
    int items_sent  = 0;
    int cycle_count = 0;
    bit tx_idle_on  = 1'b1;
    bit rx_idle_on  = 1'b1;
    logic long_hold_req = 1'b0;

    rc_serial_frame_receiver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Advance the parser model by one received byte, queueing its results
    function automatic void predict_frame_byte(input rcsfr_pkg::t_in_item it);
        logic [15:0] word;
        if (it.idle_ticks >= cfg_gap) rx_phase = rcsfr_pkg::PH_LENGTH;
        case (rx_phase)
            rcsfr_pkg::PH_LENGTH: begin
                if (it.rx_byte <= cfg_max_len && it.rx_byte <= rcsfr_pkg::FRAME_BYTES_DEF
                        && it.rx_byte > rcsfr_pkg::HEADER_OVERHEAD) begin
                    wr_idx      = '0;
                    payload_len = 5'(it.rx_byte - rcsfr_pkg::HEADER_OVERHEAD);
                    frame_sum   = rcsfr_pkg::SUM_SEED - 16'(it.rx_byte);
                    rx_phase    = rcsfr_pkg::PH_DATA;
                end else begin
                    rx_phase = rcsfr_pkg::PH_DISCARD;
                end
            end
            rcsfr_pkg::PH_DATA: begin
                store_copy[wr_idx] = it.rx_byte;
                wr_idx    = wr_idx + 5'd1;
                frame_sum = frame_sum - 16'(it.rx_byte);
                if (wr_idx == payload_len) rx_phase = rcsfr_pkg::PH_SUM_LO;
            end
            rcsfr_pkg::PH_SUM_LO: begin
                sum_lo   = it.rx_byte;
                rx_phase = rcsfr_pkg::PH_SUM_HI;
            end
            rcsfr_pkg::PH_SUM_HI: begin
                if (frame_sum == {it.rx_byte, sum_lo}) begin
                    if (store_copy[0] == cfg_servo_cmd) begin
                        // channel words come from the store as it stands
                        for (int ch = 0; ch < rcsfr_pkg::CHANNEL_COUNT_DEF; ch++) begin
                            word = {store_copy[2 * ch + 2], store_copy[2 * ch + 1]};
                            pending_results.push_back('{
                                result_kind:   rcsfr_pkg::KIND_CHANNEL,
                                channel_index: 4'(ch),
                                channel_value: word,
                                last:          (ch == rcsfr_pkg::CHANNEL_COUNT_DEF - 1)});
                        end
                    end else begin
                        pending_results.push_back('{
                            result_kind:   rcsfr_pkg::KIND_ALIVE,
                            channel_index: 4'd0,
                            channel_value: 16'd0,
                            last:          1'b1});
                    end
                end
                rx_phase = rcsfr_pkg::PH_DISCARD;
            end
            default: ;
        endcase
    endfunction

    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Result checker: one comparison per accepted result item
    always @(posedge i_clk) begin : result_check
        rcsfr_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, o_out_item);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("result_kind", 16'(want.result_kind),
                              16'(o_out_item.result_kind));
                compare_field("channel_index", 16'(want.channel_index),
                              16'(o_out_item.channel_index));
                compare_field("channel_value", want.channel_value, o_out_item.channel_value);
                compare_field("last", 16'(want.last), 16'(o_out_item.last));
            end
        end
    end

    // Output stall: random bursts, quiet stretches and the long hold-off
    initial begin : out_stall_driver
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req <= 1'b0;
                i_out_stall   <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_out_stall   <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if ($urandom_range(0, 15) == 0) begin
                repeat ($urandom_range(10, 40)) @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Offer one item, optionally after a gap, and predict it once taken
    task automatic send_byte(input logic [7:0] data_byte, input logic [7:0] gap_ticks);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= '{rx_byte: data_byte, idle_ticks: gap_ticks};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_frame_byte(i_in_item);
        items_sent++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        case (idx)
            rcsfr_pkg::CFG_GAP_THRESHOLD:    cfg_gap       = value;
            rcsfr_pkg::CFG_MAX_FRAME_LENGTH: cfg_max_len   = value[5:0];
            rcsfr_pkg::CFG_SERVO_COMMAND:    cfg_servo_cmd = value;
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] gap, input logic [5:0] max_len,
                              input logic [7:0] cmd);
        drain_results();
        write_reg(rcsfr_pkg::CFG_GAP_THRESHOLD, gap);
        write_reg(rcsfr_pkg::CFG_MAX_FRAME_LENGTH, {2'b00, max_len});
        write_reg(rcsfr_pkg::CFG_SERVO_COMMAND, cmd);
    endtask

    // Idle time that opens a frame, and idle time that keeps one going
    function automatic logic [7:0] start_gap();
        return 8'($urandom_range(255, cfg_gap));
    endfunction

    function automatic logic [7:0] inner_gap();
        return (cfg_gap == 0) ? 8'd0 : 8'($urandom_range(cfg_gap - 1, 0));
    endfunction

    // A frame is len bytes: length, command, payload, checksum low, high.
    // Only the first n_send bytes go out.
    task automatic send_frame(input int len, input logic [7:0] cmd, input bit corrupt,
                              input int n_send);
        logic [7:0]  frame [rcsfr_pkg::FRAME_BYTES_DEF];
        logic [15:0] csum;
        csum     = rcsfr_pkg::SUM_SEED - 16'(len);
        frame[0] = 8'(len);
        for (int i = 1; i <= len - rcsfr_pkg::HEADER_OVERHEAD; i++) begin
            frame[i] = (i == 1) ? cmd : 8'($urandom);
            csum     = csum - 16'(frame[i]);
        end
        if (corrupt) csum ^= 16'($urandom_range(1, 16'hFFFF));
        frame[len - 2] = csum[7:0];
        frame[len - 1] = csum[15:8];
        for (int i = 0; i < n_send; i++)
            send_byte(frame[i], (i == 0) ? start_gap() : inner_gap());
    endtask

    task automatic send_random_frame(input bit corrupt, input bit cut);
        int len;
        logic [7:0] cmd;
        len = $urandom_range(rcsfr_pkg::HEADER_OVERHEAD + 1, cfg_max_len);
        cmd = $urandom_range(0, 1) ? cfg_servo_cmd : 8'($urandom);
        send_frame(len, cmd, corrupt, cut ? $urandom_range(1, len - 1) : len);
    endtask

    // Reset values, frame kinds and bad framing at the reset settings
    task automatic test_directed_cases();
        // shortest servo frame: channels read from the untouched store
        send_frame(4, rcsfr_pkg::SERVO_COMMAND_RST, 1'b0, 4);
        // other command gives a link-alive item
        send_frame(4, 8'h11, 1'b0, 4);
        // length at the header size, then a byte ignored while discarding
        send_byte(8'd3, 8'd255);
        send_byte(8'hFF, 8'd0);
        // length beyond the store, then zero length at exactly the threshold
        send_byte(8'd33, 8'd200);
        send_byte(8'd0, rcsfr_pkg::GAP_THRESHOLD_RST);
        // bad checksum is dropped silently
        send_frame(4, rcsfr_pkg::SERVO_COMMAND_RST, 1'b1, 4);
        // frame cut short by a gap, then a short frame reusing old bytes
        send_frame(6, rcsfr_pkg::SERVO_COMMAND_RST, 1'b0, 3);
        send_frame(5, rcsfr_pkg::SERVO_COMMAND_RST, 1'b0, 5);
    endtask

    // Register extremes: zero and full gap, shortest and longest frames
    task automatic test_config_settings();
        // zero threshold: every byte restarts the parser
        set_config(8'd0, 6'd32, 8'd64);
        send_frame(8, 8'd64, 1'b0, 8);
        repeat (6) send_byte(8'($urandom_range(4, 32)), 8'($urandom));

        set_config(8'd255, 6'd4, 8'd0);
        send_frame(4, 8'd0, 1'b0, 4);
        send_byte(8'd5, 8'd255);
        send_frame(4, 8'h80, 1'b0, 4);

        set_config(8'd1, 6'd32, 8'd255);
        send_frame(32, 8'hFF, 1'b0, 32);
        send_frame(32, 8'h7E, 1'b0, 32);
        send_frame(32, 8'hFF, 1'b1, 32);

        set_config(rcsfr_pkg::GAP_THRESHOLD_RST, rcsfr_pkg::MAX_FRAME_LENGTH_RST,
                   rcsfr_pkg::SERVO_COMMAND_RST);
    endtask

    // Output held off while frames keep arriving, so the input backs up
    task automatic test_back_pressure();
        tx_idle_on = 1'b0;
        long_hold_req <= 1'b1;
        send_frame(32, cfg_servo_cmd, 1'b0, 32);
        send_frame(10, cfg_servo_cmd, 1'b0, 10);
        send_frame(4, ~cfg_servo_cmd, 1'b0, 4);
        tx_idle_on = 1'b1;
    endtask

    // Mostly good frames with random content, plus broken frames and noise
    task automatic test_random_traffic(input int n_items);
        int goal;
        int pick;
        goal = items_sent + n_items;
        while (items_sent < goal) begin
            if ($urandom_range(0, 11) == 0)
                set_config(($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                       : 8'($urandom_range(8, 100)),
                           ($urandom_range(0, 2) == 0) ? 6'($urandom_range(4, 32)) : 6'd32,
                           8'($urandom));
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                send_random_frame(1'b0, 1'b0);
            end else if (pick == 7) begin
                send_random_frame(1'b1, 1'b0);
            end else if (pick == 8) begin
                send_random_frame(1'b0, 1'b1);
            end else begin
                // out-of-range length, then random bytes and gaps
                send_byte($urandom_range(0, 1)
                              ? 8'($urandom_range(0, rcsfr_pkg::HEADER_OVERHEAD))
                              : 8'($urandom_range(cfg_max_len + 1, 255)),
                          start_gap());
                repeat ($urandom_range(1, 5)) send_byte(8'($urandom), 8'($urandom));
            end
        end
    endtask

    // Last stretch at full rate on both sides
    task automatic test_quiet_tail();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random_traffic(TAIL_ITEMS);
    endtask

    initial begin : run_tests
        cfg_gap       = rcsfr_pkg::GAP_THRESHOLD_RST;
        cfg_max_len   = rcsfr_pkg::MAX_FRAME_LENGTH_RST;
        cfg_servo_cmd = rcsfr_pkg::SERVO_COMMAND_RST;
        rx_phase      = rcsfr_pkg::PH_DISCARD;
        wr_idx        = '0;
        payload_len   = '0;
        frame_sum     = '0;
        sum_lo        = '0;
        foreach (store_copy[i]) store_copy[i] = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_config_settings();
        test_back_pressure();
        test_random_traffic(RANDOM_ITEMS);
        test_quiet_tail();
        drain_results();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* rc_serial_frame_receiver.f */
design/rcsfr_pkg.sv
design/rcsfr_ram.sv
design/rcsfr_alu.sv
design/rc_serial_frame_receiver.sv
bench/rc_serial_frame_receiver_tb.sv
